/* src/cfc_pkg.sv */
// Shared types, constants and helper functions for the command frame checker.
`timescale 1ns / 1ps

package cfc_pkg;

  // Envelope layout: byte offsets of each field in the message.
  localparam int HeaderBytes = 20;
  localparam int OffVersion  = 4;
  localparam int OffKind     = 6;
  localparam int OffReserved = 7;
  localparam int OffLength   = 8;
  localparam int OffHash     = 12;
  localparam int OffRequest  = 20;
  localparam int OffSteps    = 28;
  localparam int OffEnd      = 36;

  // Payload sizes for a plain command and for an advance command.
  localparam int NeedPlain   = 8;
  localparam int NeedAdvance = 16;

  // Default width of the message byte counter.
  localparam int DefaultCountBits = 32;

  // FNV-1a 64 constants.
  localparam logic [63:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

  // Configuration port geometry.
  localparam int CfgAddrBits = 6;
  localparam int CfgDataBits = 64;
  localparam int CfgIdxLsb   = 3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MAX_MSG    = 3'd0,
    REG_PROTO_VER  = 3'd1,
    REG_KIND_FIRST = 3'd2,
    REG_KIND_LAST  = 3'd3,
    REG_ADV_KIND   = 3'd4,
    REG_MAX_STEPS  = 3'd5
  } cfc_reg_e;

  // Result status codes, in check order meaning.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LIMIT     = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_MAGIC     = 3'd3,
    ST_VERSION   = 3'd4,
    ST_INVALID   = 3'd5,
    ST_TRAILING  = 3'd6,
    ST_CHECKSUM  = 3'd7
  } cfc_status_e;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } cfc_in_t;

  // One result transaction.
  typedef struct packed {
    cfc_status_e status;
    logic [7:0]  message_kind;
    logic [63:0] request_id;
    logic [63:0] step_count;
  } cfc_out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [31:0] max_msg;
    logic [15:0] proto_ver;
    logic [7:0]  kind_first;
    logic [7:0]  kind_last;
    logic [7:0]  adv_kind;
    logic [63:0] max_steps;
  } cfc_cfg_t;

  localparam cfc_cfg_t CfgReset = '{
    max_msg:    32'd4096,
    proto_ver:  16'd1,
    kind_first: 8'd0,
    kind_last:  8'd2,
    adv_kind:   8'd0,
    max_steps:  64'd1000000
  };

  // Fields captured from one message.
  typedef struct packed {
    logic        magic_ok;
    logic [15:0] version;
    logic [7:0]  kind;
    logic [7:0]  reserved;
    logic [31:0] decl_len;
    logic [63:0] exp_hash;
    logic [63:0] hash;
    logic [63:0] request;
    logic [63:0] steps;
  } cfc_frame_t;

  localparam cfc_frame_t FrameInit = '{
    magic_ok: 1'b1,
    version:  16'd0,
    kind:     8'd0,
    reserved: 8'd0,
    decl_len: 32'd0,
    exp_hash: 64'd0,
    hash:     FnvBasis,
    request:  64'd0,
    steps:    64'd0
  };

  // Expected magic byte at each of the first four offsets.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] tag;
    case (idx)
      2'd0:    tag = 8'h53;
      2'd1:    tag = 8'h57;
      default: tag = 8'h43;
    endcase
    return tag;
  endfunction

  // One FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a short
  // sum of shifted copies.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* src/command_frame_checker.sv */
// Top level of the command frame checker: handshake pipeline and assembly.
`timescale 1ns / 1ps

// The checker takes a command message one byte per transaction, the last
// byte flagged, and returns one result transaction per message carrying the
// first failing status (or ok), the kind byte, the request id and the step
// count. It accepts one byte every clock cycle; that rate is set by the
// FNV-1a checksum recurrence, which advances one byte per cycle. A byte is
// held in an input register, folded into the message state in the next
// cycle, and on the last byte the captured message is snapshotted and
// checked, and the check result is held in the result register. Output
// back-pressure stalls input only once the snapshot and output
// registers are both full and a last byte is waiting. Registers sit
// at byte addresses 8*i on a 64-bit port and should be written while no
// message is in flight.
module command_frame_checker #(
  parameter int CountBits = cfc_pkg::DefaultCountBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cfc_pkg::cfc_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cfc_pkg::cfc_out_t               out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cfc_pkg::CfgAddrBits-1:0] paddr,
  input  logic [cfc_pkg::CfgDataBits-1:0] pwdata,
  output logic [cfc_pkg::CfgDataBits-1:0] prdata,
  output logic                            pready
);

  cfc_pkg::cfc_cfg_t    cfg;
  cfc_pkg::cfc_in_t     s0_data_q;
  logic                 s0_valid_q;
  cfc_pkg::cfc_frame_t  frame;
  logic [CountBits-1:0] len;
  cfc_pkg::cfc_frame_t  snap_frame_q;
  logic [CountBits-1:0] snap_len_q;
  logic                 snap_valid_q;
  cfc_pkg::cfc_out_t    result;
  cfc_pkg::cfc_out_t    out_data_q;
  logic                 out_valid_q;
  logic                 out_ready, snap_ready, s0_adv, s0_ready, snap_load;

  assign pready = 1'b1;

  // Configuration registers.
  cfc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Pipeline flow control: each stage moves when the next one has room.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign snap_ready = !snap_valid_q || out_ready;
  assign s0_adv     = s0_valid_q && (!s0_data_q.last_byte || snap_ready);
  assign s0_ready   = !s0_valid_q || s0_adv;
  assign snap_load  = s0_adv && s0_data_q.last_byte;
  assign in_stall_o = !s0_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s0_ready) begin
      s0_data_q <= in_data_i;
    end
  end

  // Message state update.
  cfc_accum #(
    .CountBits (CountBits)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (s0_adv),
    .byte_i    (s0_data_q),
    .frame_o   (frame),
    .len_o     (len)
  );

  // Snapshot of a finished message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_ready) begin
      snap_valid_q <= snap_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_frame_q <= frame;
      snap_len_q   <= len;
    end
  end

  // Checks on the snapshot.
  cfc_judge #(
    .CountBits (CountBits)
  ) u_judge (
    .cfg_i    (cfg),
    .frame_i  (snap_frame_q),
    .len_i    (snap_len_q),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_q && out_ready) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Input is never stalled while the input register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_valid_q)
    else $error("input stalled with an empty input register");

  // An ok result always carries a nonzero request id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == cfc_pkg::ST_OK) |-> out_data_o.request_id != 64'd0)
    else $error("ok result with a zero request id");

  // An ok advance result carries a step count inside the allowed range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == cfc_pkg::ST_OK &&
     out_data_o.message_kind == cfg.adv_kind) |->
    (out_data_o.step_count != 64'd0 && out_data_o.step_count <= cfg.max_steps))
    else $error("ok advance result with a step count out of range");

  // Other kinds report a zero step count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.message_kind != cfg.adv_kind) |->
    out_data_o.step_count == 64'd0)
    else $error("step count reported for a kind other than advance");
`endif

endmodule

/* src/cfc_cfg_regs.sv */
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module cfc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [cfc_pkg::CfgAddrBits-1:0]  paddr_i,
  input  logic [cfc_pkg::CfgDataBits-1:0]  pwdata_i,
  output logic [cfc_pkg::CfgDataBits-1:0]  prdata_o,
  output cfc_pkg::cfc_cfg_t                cfg_o
);

  cfc_pkg::cfc_cfg_t cfg_q;
  cfc_pkg::cfc_reg_e reg_idx;
  logic              wr_en;

  // Register index from the 8-byte aligned address.
  assign reg_idx = cfc_pkg::cfc_reg_e'(paddr_i[cfc_pkg::CfgAddrBits-1:cfc_pkg::CfgIdxLsb]);
  assign wr_en   = psel_i && penable_i && pwrite_i;

  // Register writes in the access phase; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfc_pkg::CfgReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        cfc_pkg::REG_MAX_MSG:    cfg_q.max_msg    <= pwdata_i[31:0];
        cfc_pkg::REG_PROTO_VER:  cfg_q.proto_ver  <= pwdata_i[15:0];
        cfc_pkg::REG_KIND_FIRST: cfg_q.kind_first <= pwdata_i[7:0];
        cfc_pkg::REG_KIND_LAST:  cfg_q.kind_last  <= pwdata_i[7:0];
        cfc_pkg::REG_ADV_KIND:   cfg_q.adv_kind   <= pwdata_i[7:0];
        cfc_pkg::REG_MAX_STEPS:  cfg_q.max_steps  <= pwdata_i;
        default: begin
        end
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      cfc_pkg::REG_MAX_MSG:    prdata_o = {32'd0, cfg_q.max_msg};
      cfc_pkg::REG_PROTO_VER:  prdata_o = {48'd0, cfg_q.proto_ver};
      cfc_pkg::REG_KIND_FIRST: prdata_o = {56'd0, cfg_q.kind_first};
      cfc_pkg::REG_KIND_LAST:  prdata_o = {56'd0, cfg_q.kind_last};
      cfc_pkg::REG_ADV_KIND:   prdata_o = {56'd0, cfg_q.adv_kind};
      cfc_pkg::REG_MAX_STEPS:  prdata_o = cfg_q.max_steps;
      default:                 prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/cfc_accum.sv */
// Per-byte field capture, running checksum and byte counter for one message.
`timescale 1ns / 1ps

module cfc_accum #(
  parameter int CountBits = cfc_pkg::DefaultCountBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  cfc_pkg::cfc_in_t     byte_i,
  output cfc_pkg::cfc_frame_t  frame_o,
  output logic [CountBits-1:0] len_o
);

  cfc_pkg::cfc_frame_t  frame_q, frame_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [7:0]           b;
  logic [1:0]           len_lane;
  logic [2:0]           hash_lane, req_lane, steps_lane;

  assign b          = byte_i.data_byte;
  assign len_lane   = cnt_q[1:0] - 2'(cfc_pkg::OffLength);
  assign hash_lane  = cnt_q[2:0] - 3'(cfc_pkg::OffHash);
  assign req_lane   = cnt_q[2:0] - 3'(cfc_pkg::OffRequest);
  assign steps_lane = cnt_q[2:0] - 3'(cfc_pkg::OffSteps);

  // Byte counter saturates at its all-ones value.
  assign cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // Place the byte into the field its offset selects and fold payload bytes
  // into the checksum.
  always_comb begin
    frame_d = frame_q;
    if (cnt_q < CountBits'(cfc_pkg::OffVersion)) begin
      if (b != cfc_pkg::magic_byte(cnt_q[1:0])) begin
        frame_d.magic_ok = 1'b0;
      end
    end else if (cnt_q < CountBits'(cfc_pkg::OffKind)) begin
      frame_d.version[{cnt_q[0], 3'b000} +: 8] = b;
    end else if (cnt_q == CountBits'(cfc_pkg::OffKind)) begin
      frame_d.kind = b;
    end else if (cnt_q == CountBits'(cfc_pkg::OffReserved)) begin
      frame_d.reserved = b;
    end else if (cnt_q < CountBits'(cfc_pkg::OffHash)) begin
      frame_d.decl_len[{len_lane, 3'b000} +: 8] = b;
    end else if (cnt_q < CountBits'(cfc_pkg::OffRequest)) begin
      frame_d.exp_hash[{hash_lane, 3'b000} +: 8] = b;
    end else if (cnt_q < CountBits'(cfc_pkg::OffSteps)) begin
      frame_d.request[{req_lane, 3'b000} +: 8] = b;
    end else if (cnt_q < CountBits'(cfc_pkg::OffEnd)) begin
      frame_d.steps[{steps_lane, 3'b000} +: 8] = b;
    end
    if (cnt_q >= CountBits'(cfc_pkg::HeaderBytes)) begin
      frame_d.hash = cfc_pkg::fnv_step(frame_q.hash, b);
    end
  end

  // Message state; the last byte returns it to the start-of-message values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= cfc_pkg::FrameInit;
      cnt_q   <= '0;
    end else if (step_en_i) begin
      if (byte_i.last_byte) begin
        frame_q <= cfc_pkg::FrameInit;
        cnt_q   <= '0;
      end else begin
        frame_q <= frame_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  assign frame_o = frame_d;
  assign len_o   = cnt_d;

endmodule

/* src/cfc_judge.sv */
// Ordered message checks that turn a captured message into one result.
`timescale 1ns / 1ps

module cfc_judge #(
  parameter int CountBits = cfc_pkg::DefaultCountBits
) (
  input  cfc_pkg::cfc_cfg_t    cfg_i,
  input  cfc_pkg::cfc_frame_t  frame_i,
  input  logic [CountBits-1:0] len_i,
  output cfc_pkg::cfc_out_t    result_o
);

  localparam int LenBits = (CountBits > 32) ? CountBits : 32;

  logic [LenBits-1:0] len_w, max_w, avail, decl_w;
  logic [31:0]        need;
  logic               adv;
  cfc_pkg::cfc_status_e status;

  assign len_w  = LenBits'(len_i);
  assign max_w  = LenBits'(cfg_i.max_msg);
  assign decl_w = LenBits'(frame_i.decl_len);
  assign avail  = len_w - LenBits'(cfc_pkg::HeaderBytes);
  assign adv    = (frame_i.kind == cfg_i.adv_kind);
  assign need   = adv ? 32'(cfc_pkg::NeedAdvance) : 32'(cfc_pkg::NeedPlain);

  // First failing check wins.
  always_comb begin
    if (cfg_i.max_msg < 32'(cfc_pkg::HeaderBytes) || len_w > max_w) begin
      status = cfc_pkg::ST_LIMIT;
    end else if (len_w < LenBits'(cfc_pkg::HeaderBytes)) begin
      status = cfc_pkg::ST_TRUNCATED;
    end else if (!frame_i.magic_ok) begin
      status = cfc_pkg::ST_MAGIC;
    end else if (frame_i.version != cfg_i.proto_ver) begin
      status = cfc_pkg::ST_VERSION;
    end else if (frame_i.reserved != 8'd0) begin
      status = cfc_pkg::ST_INVALID;
    end else if (decl_w > avail) begin
      status = cfc_pkg::ST_TRUNCATED;
    end else if (decl_w < avail) begin
      status = cfc_pkg::ST_TRAILING;
    end else if (frame_i.hash != frame_i.exp_hash) begin
      status = cfc_pkg::ST_CHECKSUM;
    end else if (frame_i.decl_len < need) begin
      status = cfc_pkg::ST_TRUNCATED;
    end else if (frame_i.decl_len > need) begin
      status = cfc_pkg::ST_TRAILING;
    end else if (frame_i.kind < cfg_i.kind_first || frame_i.kind > cfg_i.kind_last ||
                 frame_i.request == 64'd0) begin
      status = cfc_pkg::ST_INVALID;
    end else if (adv && frame_i.steps == 64'd0) begin
      status = cfc_pkg::ST_INVALID;
    end else if (adv && frame_i.steps > cfg_i.max_steps) begin
      status = cfc_pkg::ST_LIMIT;
    end else begin
      status = cfc_pkg::ST_OK;
    end
  end

  // Captured fields go out whatever the status.
  assign result_o.status       = status;
  assign result_o.message_kind = frame_i.kind;
  assign result_o.request_id   = frame_i.request;
  assign result_o.step_count   = adv ? frame_i.steps : 64'd0;

endmodule

/* test/command_frame_checker_tb.sv */
// Self-checking testbench for the command frame checker.
`timescale 1ns / 1ps

module command_frame_checker_tb;
  import cfc_pkg::*;

  // Byte counter width handed to the block.
  localparam int CountBits = DefaultCountBits;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [31:0] MagicTag = "SWCC";
  localparam logic [2:0] RegSpare = 3'd6;
  localparam int SettleCycles = 8;
  localparam int TotalBytes = 1100;

  // Predicts the verdict of each message from the bytes that are accepted.
  class frame_scoreboard;
    cfc_cfg_t regs;
    cfc_frame_t seen;
    logic [63:0] count;
    logic [63:0] top;
    cfc_out_t verdicts_due[$];
    int errors;
    int messages;
    int tally[8];

    function new(int bits);
      regs = CfgReset;
      seen = FrameInit;
      count = '0;
      top = (bits >= 64) ? '1 : (64'd1 << bits) - 64'd1;
      errors = 0;
      messages = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_MAX_MSG:    regs.max_msg = v[31:0];
        REG_PROTO_VER:  regs.proto_ver = v[15:0];
        REG_KIND_FIRST: regs.kind_first = v[7:0];
        REG_KIND_LAST:  regs.kind_last = v[7:0];
        REG_ADV_KIND:   regs.adv_kind = v[7:0];
        REG_MAX_STEPS:  regs.max_steps = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] reg_value(logic [2:0] idx);
      logic [63:0] v;
      case (idx)
        REG_MAX_MSG:    v = {32'd0, regs.max_msg};
        REG_PROTO_VER:  v = {48'd0, regs.proto_ver};
        REG_KIND_FIRST: v = {56'd0, regs.kind_first};
        REG_KIND_LAST:  v = {56'd0, regs.kind_last};
        REG_ADV_KIND:   v = {56'd0, regs.adv_kind};
        default:        v = regs.max_steps;
      endcase
      return v;
    endfunction

    // First failing check of a finished message, in the block's check order.
    function cfc_status_e grade(logic [63:0] len);
      logic [63:0] avail;
      logic [63:0] need;
      bit adv;
      adv = (seen.kind == regs.adv_kind);
      if (regs.max_msg < HeaderBytes || len > regs.max_msg) return ST_LIMIT;
      if (len < HeaderBytes) return ST_TRUNCATED;
      if (!seen.magic_ok) return ST_MAGIC;
      if (seen.version != regs.proto_ver) return ST_VERSION;
      if (seen.reserved != 8'd0) return ST_INVALID;
      avail = len - HeaderBytes;
      if (seen.decl_len > avail) return ST_TRUNCATED;
      if (seen.decl_len < avail) return ST_TRAILING;
      if (seen.hash != seen.exp_hash) return ST_CHECKSUM;
      need = adv ? NeedAdvance : NeedPlain;
      if (seen.decl_len < need) return ST_TRUNCATED;
      if (seen.decl_len > need) return ST_TRAILING;
      if (seen.kind < regs.kind_first || seen.kind > regs.kind_last) return ST_INVALID;
      if (seen.request == 64'd0) return ST_INVALID;
      if (adv && seen.steps == 64'd0) return ST_INVALID;
      if (adv && seen.steps > regs.max_steps) return ST_LIMIT;
      return ST_OK;
    endfunction

    // Folds one accepted byte into the message and queues a verdict on the last one.
    function void take_byte(cfc_in_t t);
      logic [7:0] b;
      logic [63:0] len;
      cfc_out_t v;
      int k;
      b = t.data_byte;
      k = (count < OffEnd) ? int'(count) : OffEnd;
      if (k < OffVersion) begin
        if (b != MagicTag[8*(3-k) +: 8]) seen.magic_ok = 1'b0;
      end else if (k < OffKind) begin
        seen.version[8*(k-OffVersion) +: 8] = b;
      end else if (k == OffKind) begin
        seen.kind = b;
      end else if (k == OffReserved) begin
        seen.reserved = b;
      end else if (k < OffHash) begin
        seen.decl_len[8*(k-OffLength) +: 8] = b;
      end else if (k < OffRequest) begin
        seen.exp_hash[8*(k-OffHash) +: 8] = b;
      end else if (k < OffSteps) begin
        seen.request[8*(k-OffRequest) +: 8] = b;
      end else if (k < OffEnd) begin
        seen.steps[8*(k-OffSteps) +: 8] = b;
      end
      if (count >= HeaderBytes) seen.hash = (seen.hash ^ {56'd0, b}) * FnvPrime;
      len = (count >= top) ? top : count + 64'd1;
      count = len;
      if (t.last_byte) begin
        v.status = grade(len);
        v.message_kind = seen.kind;
        v.request_id = seen.request;
        v.step_count = (seen.kind == regs.adv_kind) ? seen.steps : 64'd0;
        verdicts_due.push_back(v);
        tally[v.status]++;
        messages++;
        seen = FrameInit;
        count = '0;
      end
    endfunction

    function void check_verdict(cfc_out_t got);
      cfc_out_t want;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result transaction: status %0d", got.status);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.message_kind !== want.message_kind) begin
        $error("message_kind: expected %0d, got %0d", want.message_kind, got.message_kind);
        errors++;
      end
      if (got.request_id !== want.request_id) begin
        $error("request_id: expected %0h, got %0h", want.request_id, got.request_id);
        errors++;
      end
      if (got.step_count !== want.step_count) begin
        $error("step_count: expected %0h, got %0h", want.step_count, got.step_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  cfc_in_t in_data = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [CfgDataBits-1:0] pwdata = '0;
  logic in_stall_o;
  logic out_valid_o;
  cfc_out_t out_data_o;
  logic [CfgDataBits-1:0] prdata;
  logic pready;

  frame_scoreboard board = new(CountBits);
  logic [7:0] frame_q[$];
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  command_frame_checker #(.CountBits(CountBits)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver switches between calm, light, heavy and periodic stalling.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((mode_left % 8) < 5);
    endcase
  end

  // Handshake signals are stable between the falling and the next rising edge,
  // so a transaction seen here is the one taken at the coming rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) board.check_verdict(out_data_o);
      if (in_valid && !in_stall_o) board.take_byte(in_data);
    end
  end

  task automatic send_byte(input cfc_in_t item);
    bit taken;
    in_valid <= 1'b1;
    in_data <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
  endtask

  // Sends the staged message in bursts with random gaps between them.
  task automatic send_frame();
    cfc_in_t item;
    foreach (frame_q[i]) begin
      item.data_byte = frame_q[i];
      item.last_byte = (i == frame_q.size() - 1);
      send_byte(item);
      bytes_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 256)
                                                  : $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    frames_sent++;
  endtask

  // Holds the sender until every verdict has come back and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input logic [2:0] idx, input bit wr, input logic [63:0] wdata,
                           output logic [63:0] rdata);
    bit done;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CfgAddrBits'(idx) << CfgIdxLsb;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      rdata = prdata;
      done = pready;
      @(posedge clk_i);
    end
  endtask

  task automatic bus_idle();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_reg(input logic [2:0] idx);
    logic [63:0] got;
    apb_cycle(idx, 1'b0, '0, got);
    if (got !== board.reg_value(idx)) begin
      $error("register %0d: expected %0h, got %0h", idx, board.reg_value(idx), got);
      board.errors++;
    end
  endtask

  task automatic verify_all();
    verify_reg(REG_MAX_MSG);
    verify_reg(REG_PROTO_VER);
    verify_reg(REG_KIND_FIRST);
    verify_reg(REG_KIND_LAST);
    verify_reg(REG_ADV_KIND);
    verify_reg(REG_MAX_STEPS);
  endtask

  // Writes a register and reads it back; the spare index is only written.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    logic [63:0] unused;
    apb_cycle(idx, 1'b1, v, unused);
    board.set_reg(idx, v);
    if (idx != RegSpare) verify_reg(idx);
  endtask

  task automatic push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) frame_q.push_back(v[8*i +: 8]);
  endtask

  task automatic patch_le(input int off, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) frame_q[off + i] = v[8*i +: 8];
  endtask

  // Stages a complete message whose length field and checksum match its payload.
  task automatic compose_frame(input logic [15:0] ver, input logic [7:0] kind,
                               input logic [7:0] rsvd, input logic [63:0] req,
                               input logic [63:0] steps, input bit with_steps,
                               input int extra);
    logic [7:0] body[$];
    logic [63:0] sum;
    body = {};
    for (int i = 0; i < 8; i++) body.push_back(req[8*i +: 8]);
    if (with_steps) for (int i = 0; i < 8; i++) body.push_back(steps[8*i +: 8]);
    repeat (extra) body.push_back(8'($urandom));
    sum = FnvBasis;
    foreach (body[i]) sum = (sum ^ {56'd0, body[i]}) * FnvPrime;
    frame_q = {};
    for (int i = 0; i < 4; i++) frame_q.push_back(MagicTag[8*(3-i) +: 8]);
    push_le(ver, 2);
    frame_q.push_back(kind);
    frame_q.push_back(rsvd);
    push_le(body.size(), 4);
    push_le(sum, 8);
    frame_q = {frame_q, body};
  endtask

  // Mostly well-formed messages for the current settings, some of them damaged.
  task automatic random_frame();
    cfc_cfg_t c;
    logic [7:0] kind;
    logic [63:0] req;
    logic [63:0] steps;
    int extra;
    int n;
    c = board.regs;
    if ($urandom_range(0, 9) < 8 && c.kind_first <= c.kind_last)
      kind = $urandom_range(c.kind_first, c.kind_last);
    else
      kind = $urandom;
    if ($urandom_range(0, 2) == 0) kind = c.adv_kind;
    req = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) req = '0;
    case ($urandom_range(0, 7))
      0: steps = '0;
      1: steps = c.max_steps;
      2: steps = c.max_steps + 64'd1;
      default: begin
        if (c.max_steps == 0) steps = {$urandom, $urandom};
        else steps = ({$urandom, $urandom} % c.max_steps) + 64'd1;
      end
    endcase
    extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : 0;
    compose_frame(c.proto_ver, kind, 8'd0, req, steps, kind == c.adv_kind, extra);
    if ($urandom_range(0, 9) < 3) begin
      n = frame_q.size() - HeaderBytes;
      case ($urandom_range(0, 9))
        0: frame_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        1: patch_le(OffVersion, $urandom, 2);
        2: frame_q[OffReserved] = 8'($urandom_range(1, 255));
        3: patch_le(OffLength, $urandom_range(0, 1) ? n + $urandom_range(1, 3)
                                                     : n - $urandom_range(1, 3), 4);
        4: frame_q[OffHash + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
        5: begin
          n = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > n) void'(frame_q.pop_back());
        end
        6: repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
        7: begin
          frame_q = {};
          repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
        end
        8: frame_q[$urandom_range(HeaderBytes, frame_q.size() - 1)] ^= 8'($urandom_range(1, 255));
        default: frame_q[OffKind] = $urandom;
      endcase
    end
  endtask

  // Register settings of one phase: the two extremes first, then random mixes.
  task automatic load_settings(input int phase);
    logic [63:0] v[6];
    case (phase)
      0: v = '{64'd20, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
      1: v = '{64'hFFFF_FFFF, 64'hFFFF, 64'd255, 64'd255, 64'd255, '1};
      default: begin
        case ($urandom_range(0, 2))
          0: v[0] = $urandom_range(20, 60);
          1: v[0] = 64'hFFFF_FFFF;
          default: v[0] = $urandom_range(64, 4096);
        endcase
        case ($urandom_range(0, 2))
          0: v[1] = 64'd0;
          1: v[1] = 64'hFFFF;
          default: v[1] = $urandom_range(0, 65535);
        endcase
        v[2] = $urandom_range(0, 255);
        v[3] = $urandom_range(0, 255);
        if ($urandom_range(0, 4) != 0 && v[2] > v[3]) begin
          v[4] = v[2];
          v[2] = v[3];
          v[3] = v[4];
        end
        if ($urandom_range(0, 1) == 0 && v[2] <= v[3]) v[4] = $urandom_range(v[2], v[3]);
        else v[4] = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
          0: v[5] = '0;
          1: v[5] = '1;
          2: v[5] = $urandom_range(1, 1000);
          default: v[5] = {$urandom, $urandom};
        endcase
      end
    endcase
    write_reg(REG_MAX_MSG, v[0]);
    write_reg(REG_PROTO_VER, v[1]);
    write_reg(REG_KIND_FIRST, v[2]);
    write_reg(REG_KIND_LAST, v[3]);
    write_reg(REG_ADV_KIND, v[4]);
    write_reg(REG_MAX_STEPS, v[5]);
    bus_idle();
    settings++;
  endtask

  initial begin
    logic [63:0] req;
    int phase;
    int nf;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers.
    verify_all();
    bus_idle();
    settings++;

    // Directed messages under the reset settings.
    req = {$urandom, $urandom} | 64'd1;
    frame_q = {MagicTag[31:24]};
    send_frame();
    compose_frame(16'd1, 8'd5, 8'd0, req, '0, 1'b0, 0);
    while (frame_q.size() > OffReserved) void'(frame_q.pop_back());
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    send_frame();
    compose_frame(16'd1, 8'd0, 8'd0, req, 64'd1000000, 1'b1, 0);
    send_frame();
    compose_frame(16'd1, 8'd0, 8'd0, req, 64'd1000001, 1'b1, 0);
    send_frame();
    compose_frame(16'd1, 8'd0, 8'd0, req, 64'd0, 1'b1, 0);
    send_frame();
    compose_frame(16'd1, 8'd2, 8'd0, '0, '0, 1'b0, 0);
    send_frame();
    compose_frame(16'd1, 8'd3, 8'd0, req, '0, 1'b0, 0);
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    frame_q[2] = 8'h00;
    send_frame();
    compose_frame(16'd2, 8'd1, 8'd0, req, '0, 1'b0, 0);
    send_frame();
    compose_frame(16'd1, 8'd1, 8'h80, req, '0, 1'b0, 0);
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    patch_le(OffLength, NeedPlain + 1, 4);
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    patch_le(OffLength, NeedPlain - 1, 4);
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    frame_q[OffHash + 7] ^= 8'hFF;
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 8);
    send_frame();
    compose_frame(16'd1, 8'd0, 8'd0, req, '0, 1'b0, 0);
    send_frame();
    frame_q = {};
    repeat (HeaderBytes) frame_q.push_back(8'hFF);
    send_frame();
    drain();

    // A write to an index past the register file must change nothing.
    write_reg(RegSpare, '1);
    verify_all();

    // Smallest allowed length limit: a bare header passes it, one more byte does not.
    write_reg(REG_MAX_MSG, 64'd20);
    bus_idle();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    while (frame_q.size() > HeaderBytes) void'(frame_q.pop_back());
    send_frame();
    compose_frame(16'd1, 8'd1, 8'd0, req, '0, 1'b0, 0);
    while (frame_q.size() > HeaderBytes + 1) void'(frame_q.pop_back());
    send_frame();

    // Random phases, each under its own register settings, until the byte budget is spent.
    phase = 0;
    while (bytes_sent < TotalBytes) begin
      drain();
      load_settings(phase);
      nf = $urandom_range(4, 10);
      for (int f = 0; f < nf && bytes_sent < TotalBytes; f++) begin
        random_frame();
        send_frame();
      end
      phase++;
    end
    drain();

    $display("Checked %0d messages of %0d bytes across %0d register settings.",
             board.messages, bytes_sent, settings);
    $display({"Status mix ok/limit/truncated/magic/version/invalid/trailing/checksum: ",
              "%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d"},
             board.tally[0], board.tally[1], board.tally[2], board.tally[3],
             board.tally[4], board.tally[5], board.tally[6], board.tally[7]);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/cfc_pkg.sv
src/cfc_cfg_regs.sv
src/cfc_accum.sv
src/cfc_judge.sv
src/command_frame_checker.sv
test/command_frame_checker_tb.sv
